// ----- rtl/iidl_pkg.sv -----
// Shared types and constants for the indexed insert/delete list.
package iidl_pkg;

  localparam int DEPTH       = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 5;
  localparam int DATA_W      = 32;
  localparam int STAT_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_REMOVE_HEAD = 3'd1,
    OP_READ        = 3'd2,
    OP_INSERT      = 3'd3,
    OP_DELETE      = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  index;
    logic [DATA_W-1:0] data_in;
  } in_beat_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data_out;
    logic [POS_W-1:0]  length;
  } out_beat_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [CNT_W-1:0]      pos;
    logic [WORD_WIDTH-1:0] word;
  } cell_ctl_t;

endpackage

// ----- rtl/indexed_insert_delete_list.sv -----
// Top level of the indexed insert/delete list built as a chain of cells.
//
//   Channel | Direction | Handshake           | Beat
//   --------+-----------+---------------------+---------------------------
//   in_     | input     | in_valid / in_stall | func, index, data_in
//   out_    | output    | out_valid/out_stall | status, data_out, length
//
// Every accepted beat is decoded in the cycle it arrives; all cells shift in
// parallel at that same edge, so an insert or delete of any position completes
// at that edge. The result lands in an output register in the cycle after acceptance.
// A new beat is taken every cycle unless the output register is full and the
// downstream side stalls it. Reset (rst_n low, synchronous) empties the list
// and drops the output valid; the cell contents are not cleared, since only
// entries below the length are ever read.
module indexed_insert_delete_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iidl_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output iidl_pkg::out_beat_t out_beat
);
  import iidl_pkg::*;

  logic [WORD_WIDTH-1:0] words [DEPTH];
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_beat_t             out_beat_r;
  out_beat_t             out_beat_nxt;

  logic                  accept;
  logic                  full;
  logic [POS_W-1:0]      cnt_ext;
  logic [IDX_W-1:0]      rd_sel;
  logic [WORD_WIDTH-1:0] rd_word;
  logic                  do_ins;
  logic                  do_del;
  logic                  do_read;
  logic [CNT_W-1:0]      pos;
  status_t               status;
  cell_ctl_t             ctl;

  // The input is held off only while a finished result waits to be taken.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign cnt_ext = POS_W'(count_r);

  // Remove head always reads the first cell; read and delete use the index.
  assign rd_sel  = (op_t'(in_beat.func) == OP_REMOVE_HEAD) ? '0 : IDX_W'(in_beat.index);
  assign rd_word = words[rd_sel];

  // Operation decode and range checks. Insert checks the index before the
  // full condition, so an index past the tail reports a range error even when
  // the list is full.
  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    do_read = 1'b0;
    pos     = CNT_W'(in_beat.index);
    status  = ST_OK;
    case (op_t'(in_beat.func))
      OP_APPEND: begin
        pos = count_r;
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REMOVE_HEAD: begin
        pos = '0;
        if (count_r == '0) begin
          status = ST_RANGE;
        end else begin
          do_del  = 1'b1;
          do_read = 1'b1;
        end
      end
      OP_READ: begin
        if (in_beat.index >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      OP_INSERT: begin
        if (in_beat.index > cnt_ext) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DELETE: begin
        if (in_beat.index >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          do_del  = 1'b1;
          do_read = 1'b1;
        end
      end
      default: begin
        // Unused operation codes leave the list as it is and report ok.
      end
    endcase
  end

  // Command for the chain; nothing moves unless a beat is accepted.
  assign ctl.ins  = accept & do_ins;
  assign ctl.del  = accept & do_del;
  assign ctl.pos  = pos;
  assign ctl.word = in_beat.data_in[WORD_WIDTH-1:0];

  // The chain: each cell sees its lower and upper neighbor. The bottom cell
  // never takes from below, and the top cell refills from itself on delete.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower_w;
    logic [WORD_WIDTH-1:0] upper_w;
    if (g == 0) begin : g_bot
      assign lower_w = ctl.word;
    end else begin : g_mid_lo
      assign lower_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign upper_w = words[g];
    end else begin : g_mid_hi
      assign upper_w = words[g+1];
    end
    iidl_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word       (words[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result register: loaded on accept, cleared of valid once taken.
  always_comb begin
    out_beat_nxt          = out_beat_r;
    out_valid_nxt         = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_beat_nxt.status   = status;
      out_beat_nxt.data_out = do_read ? DATA_W'(rd_word) : '0;
      out_beat_nxt.length   = POS_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ----- rtl/iidl_cell.sv -----
// One storage cell of the list chain, shifting toward either neighbor.
module iidl_cell (
  input  logic                            clk,
  input  logic [iidl_pkg::IDX_W-1:0]      cell_idx,
  input  iidl_pkg::cell_ctl_t             ctl,
  input  logic [iidl_pkg::WORD_WIDTH-1:0] lower_word,
  input  logic [iidl_pkg::WORD_WIDTH-1:0] upper_word,
  output logic [iidl_pkg::WORD_WIDTH-1:0] word
);
  import iidl_pkg::*;

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;
  logic [CNT_W-1:0]      me;

  assign me = CNT_W'(cell_idx);

  // On insert, cells above the position take their lower neighbor's word and
  // the cell at the position loads the new word. On delete, cells from the
  // position up take their upper neighbor's word.
  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (me == ctl.pos) begin
        word_nxt = ctl.word;
      end else if (me > ctl.pos) begin
        word_nxt = lower_word;
      end
    end else if (ctl.del) begin
      if (me >= ctl.pos) begin
        word_nxt = upper_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule
